// ===== src/dca_pkg.sv =====
// shared constants and controller/datapath interface types for the dictionary code assigner
// no dependencies
package dca_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int KEY_BITS_DEF = 32;
    localparam int IN_KEY_W     = 32;
    localparam int CMD_W        = 2;
    localparam int CODE_W       = 9;
    localparam int STATUS_W     = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LEARN  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic capture;
        logic rd;
        logic cmp;
        logic fin;
    } dca_ctl_t;

    typedef struct packed {
        logic scan_done;
        logic hit;
        logic out_free;
    } dca_sts_t;

endpackage

// ===== src/dca_ctrl.sv =====
// sequencer for the key table scan: capture, read, compare, finish
// depends on dca_pkg
module dca_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dca_pkg::dca_sts_t sts,
    output dca_pkg::dca_ctl_t ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        ctl         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    ctl.rd     = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctl.cmp    = 1'b1;
                state_next = sts.hit ? S_FIN : S_READ;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    ctl.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/dca_datapath.sv =====
// key table memory, entry count, scan index and result register
// depends on dca_pkg
module dca_datapath
#(
    parameter int CAPACITY = dca_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = dca_pkg::KEY_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic        [dca_pkg::CMD_W-1:0]    in_cmd,
    input  logic signed [dca_pkg::IN_KEY_W-1:0] in_key,
    input  dca_pkg::dca_ctl_t                   ctl,
    output dca_pkg::dca_sts_t                   sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic        [dca_pkg::CODE_W-1:0]   out_code,
    output logic        [dca_pkg::STATUS_W-1:0] out_status,
    output logic                                out_new
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [KEY_BITS-1:0] mem [CAPACITY];

    logic [KEY_BITS-1:0]         key_in;
    logic [KEY_BITS-1:0]         key_reg;
    logic [KEY_BITS-1:0]         rd_reg;
    logic [dca_pkg::CMD_W-1:0]   cmd_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        found_reg;
    logic                        out_valid_reg;
    logic [dca_pkg::CODE_W-1:0]  out_code_reg;
    logic [dca_pkg::STATUS_W-1:0] out_status_reg;
    logic                        out_new_reg;

    logic                        full;
    logic                        do_append;
    logic [CNT_W-1:0]            found_code;
    logic [CNT_W-1:0]            append_code;
    logic [dca_pkg::CODE_W-1:0]  res_code;
    logic [dca_pkg::STATUS_W-1:0] res_status;
    logic                        res_new;

    generate
        if (KEY_BITS <= dca_pkg::IN_KEY_W)
        begin : g_key_trunc
            assign key_in = in_key[KEY_BITS-1:0];
        end
        else
        begin : g_key_sext
            assign key_in = {{(KEY_BITS - dca_pkg::IN_KEY_W){in_key[dca_pkg::IN_KEY_W-1]}},
                             in_key};
        end
    endgenerate

    assign sts.scan_done = (cmd_reg == dca_pkg::CMD_CLEAR) || (idx_reg == count_reg);
    assign sts.hit       = (rd_reg == key_reg);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign full        = (count_reg == CAP_CNT);
    assign found_code  = CNT_W'(idx_reg + 1'b1);
    assign append_code = CNT_W'(count_reg + 1'b1);

    // result of the finished scan
    always_comb
    begin
        res_code   = '0;
        res_status = dca_pkg::ST_OK;
        res_new    = 1'b0;
        do_append  = 1'b0;
        count_next = count_reg;
        unique case (cmd_reg)
            dca_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            dca_pkg::CMD_LOOKUP:
            begin
                if (found_reg)
                begin
                    res_code = dca_pkg::CODE_W'(found_code);
                end
                else
                begin
                    res_status = dca_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                if (found_reg)
                begin
                    res_code = dca_pkg::CODE_W'(found_code);
                    if (cmd_reg == dca_pkg::CMD_LOAD)
                    begin
                        res_status = dca_pkg::ST_DUPLICATE;
                    end
                end
                else if (full)
                begin
                    res_status = dca_pkg::ST_FULL;
                end
                else
                begin
                    res_code   = dca_pkg::CODE_W'(append_code);
                    res_new    = 1'b1;
                    do_append  = 1'b1;
                    count_next = append_code;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fin && do_append)
        begin
            mem[count_reg[AW-1:0]] <= key_reg;
        end
        if (ctl.rd)
        begin
            rd_reg <= mem[idx_reg[AW-1:0]];
        end
        if (ctl.capture)
        begin
            key_reg <= key_in;
        end
        if (ctl.fin)
        begin
            out_code_reg   <= res_code;
            out_status_reg <= res_status;
            out_new_reg    <= res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= dca_pkg::CMD_CLEAR;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.capture)
            begin
                cmd_reg   <= in_cmd;
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (ctl.cmp)
            begin
                if (sts.hit)
                begin
                    found_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= CNT_W'(idx_reg + 1'b1);
                end
            end
            if (ctl.fin)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_code   = out_code_reg;
    assign out_status = out_status_reg;
    assign out_new    = out_new_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= count_reg)
        else $error("scan index past entry count");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fin && do_append |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("append did not grow the table by one");

    a_new_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_new_reg |-> out_status_reg == dca_pkg::ST_OK)
        else $error("new key reported with non-ok status");

endmodule

// ===== src/dictionary_code_assigner_core.sv =====
// top level of the dictionary code assigner: stream ports, controller and datapath
// depends on dca_pkg, dca_ctrl, dca_datapath
//
// Keys are matched against the table by a linear scan through a single-port key memory,
// one stored entry at a time (registered read, then compare). A clear goes from capture
// straight to the finish step, a hit ends the scan at the compare that matches, and a miss
// reads and compares every stored entry first; when the result register is still full,
// the finished scan waits until the output side frees it.
// One command is in flight at a time, and the next beat is accepted only once the
// result is registered; the result register lets the next beat be accepted
// while the previous result still waits on the output side.
module dictionary_code_assigner_core
#(
    parameter int CAPACITY = dca_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = dca_pkg::KEY_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // key[31:0]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // code[8:0], zero[15:9]
    output logic [2:0]  m_tuser    // status[1:0], is_new[2]
);

    dca_pkg::dca_ctl_t ctl;
    dca_pkg::dca_sts_t sts;

    logic [dca_pkg::CODE_W-1:0]   code;
    logic [dca_pkg::STATUS_W-1:0] status;
    logic                         is_new;

    dca_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    dca_datapath
    #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_cmd     (s_tuser),
        .in_key     ($signed(s_tdata)),
        .ctl        (ctl),
        .sts        (sts),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_code   (code),
        .out_status (status),
        .out_new    (is_new)
    );

    assign m_tdata = {{(16 - dca_pkg::CODE_W){1'b0}}, code};
    assign m_tuser = {is_new, status};

endmodule

// ===== bench/tb_dictionary_code_assigner_core.sv =====
// self-checking testbench for dictionary_code_assigner_core: directed table, full-table case,
// then random command mixes under three stall profiles, checked against an in-bench predictor
// depends on dca_pkg and dictionary_code_assigner_core
module tb_dictionary_code_assigner_core;

    localparam int TABLE_DEPTH    = dca_pkg::CAPACITY_DEF;
    localparam int POOL_SIZE      = 48;
    localparam int RAND_PER_PHASE = 90;
    localparam int LONG_HOLD      = 400;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int NUM_ROWS       = 24;

    typedef struct packed {
        logic [dca_pkg::CODE_W-1:0]   code;
        logic [dca_pkg::STATUS_W-1:0] status;
        logic                         is_new;
    } dict_result_t;

    typedef struct packed {
        logic                         fill;
        logic [dca_pkg::CMD_W-1:0]    cmd;
        logic [dca_pkg::IN_KEY_W-1:0] key;
        logic                         typed;
        logic [dca_pkg::CODE_W-1:0]   code;
        logic [dca_pkg::STATUS_W-1:0] status;
        logic                         is_new;
    } dict_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    logic [dca_pkg::IN_KEY_W-1:0] dict_keys [TABLE_DEPTH];
    int                           dict_count = 0;
    logic [dca_pkg::IN_KEY_W-1:0] key_pool [POOL_SIZE];
    dict_result_t                 pending_codes [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int new_keys_seen = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int quiet_cycles = 0;

    dict_row_t directed_rows [NUM_ROWS] = '{
        '{1'b0, dca_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b1, 9'd0,   dca_pkg::ST_NOT_FOUND, 1'b0},
        '{1'b0, dca_pkg::CMD_LEARN,  32'h0000_0000, 1'b1, 9'd1,   dca_pkg::ST_OK,        1'b1},
        '{1'b0, dca_pkg::CMD_LOAD,   32'h7FFF_FFFF, 1'b1, 9'd2,   dca_pkg::ST_OK,        1'b1},
        '{1'b0, dca_pkg::CMD_LOAD,   32'h8000_0000, 1'b1, 9'd3,   dca_pkg::ST_OK,        1'b1},
        '{1'b0, dca_pkg::CMD_LOAD,   32'hFFFF_FFFF, 1'b1, 9'd4,   dca_pkg::ST_OK,        1'b1},
        '{1'b0, dca_pkg::CMD_LOAD,   32'h7FFF_FFFF, 1'b1, 9'd2,   dca_pkg::ST_DUPLICATE, 1'b0},
        '{1'b0, dca_pkg::CMD_LEARN,  32'h8000_0000, 1'b1, 9'd3,   dca_pkg::ST_OK,        1'b0},
        '{1'b0, dca_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 1'b1, 9'd4,   dca_pkg::ST_OK,        1'b0},
        '{1'b0, dca_pkg::CMD_LOOKUP, 32'h1234_5678, 1'b1, 9'd0,   dca_pkg::ST_NOT_FOUND, 1'b0},
        '{1'b0, dca_pkg::CMD_CLEAR,  32'hDEAD_BEEF, 1'b1, 9'd0,   dca_pkg::ST_OK,        1'b0},
        '{1'b0, dca_pkg::CMD_LOOKUP, 32'h7FFF_FFFF, 1'b1, 9'd0,   dca_pkg::ST_NOT_FOUND, 1'b0},
        '{1'b0, dca_pkg::CMD_LEARN,  32'hA5A5_A5A5, 1'b1, 9'd1,   dca_pkg::ST_OK,        1'b1},
        '{1'b0, dca_pkg::CMD_LEARN,  32'h5A5A_5A5A, 1'b1, 9'd2,   dca_pkg::ST_OK,        1'b1},
        '{1'b0, dca_pkg::CMD_LEARN,  32'hA5A5_A5A5, 1'b1, 9'd1,   dca_pkg::ST_OK,        1'b0},
        '{1'b0, dca_pkg::CMD_LOAD,   32'h5A5A_5A5A, 1'b1, 9'd2,   dca_pkg::ST_DUPLICATE, 1'b0},
        '{1'b0, dca_pkg::CMD_CLEAR,  32'h0000_0000, 1'b1, 9'd0,   dca_pkg::ST_OK,        1'b0},
        '{1'b1, dca_pkg::CMD_LOAD,   32'h0001_0000, 1'b0, 9'd0,   dca_pkg::ST_OK,        1'b0},
        '{1'b0, dca_pkg::CMD_LOAD,   32'h0002_0000, 1'b1, 9'd0,   dca_pkg::ST_FULL,      1'b0},
        '{1'b0, dca_pkg::CMD_LEARN,  32'h0003_0000, 1'b1, 9'd0,   dca_pkg::ST_FULL,      1'b0},
        '{1'b0, dca_pkg::CMD_LOOKUP, 32'h0001_00FF, 1'b1, 9'd256, dca_pkg::ST_OK,        1'b0},
        '{1'b0, dca_pkg::CMD_LEARN,  32'h0001_0000, 1'b1, 9'd1,   dca_pkg::ST_OK,        1'b0},
        '{1'b0, dca_pkg::CMD_LOAD,   32'h0001_00FF, 1'b1, 9'd256, dca_pkg::ST_DUPLICATE, 1'b0},
        '{1'b0, dca_pkg::CMD_LOOKUP, 32'h0002_0000, 1'b1, 9'd0,   dca_pkg::ST_NOT_FOUND, 1'b0},
        '{1'b0, dca_pkg::CMD_CLEAR,  32'h0000_0000, 1'b1, 9'd0,   dca_pkg::ST_OK,        1'b0}
    };

    dictionary_code_assigner_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic dict_result_t encode_key(input logic [dca_pkg::CMD_W-1:0] cmd,
                                                input logic [dca_pkg::IN_KEY_W-1:0] key);
        dict_result_t r;
        int hit;
        int i;
        r = '0;
        hit = 0;
        if (cmd == dca_pkg::CMD_CLEAR)
        begin
            dict_count = 0;
        end
        else
        begin
            for (i = 0; i < dict_count; i++)
            begin
                if (hit == 0 && dict_keys[i] == key)
                    hit = i + 1;
            end
            if (hit != 0)
            begin
                r.code = hit[dca_pkg::CODE_W-1:0];
                if (cmd == dca_pkg::CMD_LOAD)
                    r.status = dca_pkg::ST_DUPLICATE;
            end
            else if (cmd == dca_pkg::CMD_LOOKUP)
            begin
                r.status = dca_pkg::ST_NOT_FOUND;
            end
            else if (dict_count >= TABLE_DEPTH)
            begin
                r.status = dca_pkg::ST_FULL;
            end
            else
            begin
                dict_keys[dict_count] = key;
                dict_count++;
                r.code = dict_count[dca_pkg::CODE_W-1:0];
                r.is_new = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic send_beat(input logic [dca_pkg::CMD_W-1:0] cmd,
                             input logic [dca_pkg::IN_KEY_W-1:0] key,
                             input logic typed, input dict_result_t typed_result);
        dict_result_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= key;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_in++;
        r = encode_key(cmd, key);
        pending_codes.insert(pending_codes.size(), typed ? typed_result : r);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_codes.size() != 0);
    endtask

    function automatic logic [dca_pkg::CMD_W-1:0] pick_cmd();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return dca_pkg::CMD_CLEAR;
        if (r < 24)
            return dca_pkg::CMD_LOAD;
        if (r < 64)
            return dca_pkg::CMD_LEARN;
        return dca_pkg::CMD_LOOKUP;
    endfunction

    function automatic logic [dca_pkg::IN_KEY_W-1:0] pick_key();
        if ($urandom_range(3) == 0)
            return $urandom();
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    task automatic run_random(input int count, input bit with_hold);
        int n;
        for (n = 0; n < count; n++)
        begin
            if (with_hold && n == count / 4)
                hold_asked++;
            send_beat(pick_cmd(), pick_key(), 1'b0, '0);
        end
    endtask

    // receiver side: random back-pressure plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        dict_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_out++;
            if (pending_codes.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result beat: tdata=%h tuser=%h", m_tdata, m_tuser);
            end
            else
            begin
                want = pending_codes.pop_front();
                status_seen[want.status]++;
                if (want.is_new)
                    new_keys_seen++;
                if (m_tdata !== {{(16 - dca_pkg::CODE_W){1'b0}}, want.code}
                    || m_tuser[dca_pkg::STATUS_W-1:0] !== want.status
                    || m_tuser[2] !== want.is_new)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch at beat %0d: code %0d/%0d status %0d/%0d new %0d/%0d",
                                 beats_out, want.code, m_tdata, want.status,
                                 m_tuser[dca_pkg::STATUS_W-1:0], want.is_new, m_tuser[2]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results pending",
                     quiet_cycles, pending_codes.size());
            $display("[dictionary_code_assigner_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        int i;
        int j;
        dict_row_t row;
        for (i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'h8000_0000;
        key_pool[2] = 32'h7FFF_FFFF;
        key_pool[3] = 32'hFFFF_FFFF;

        send_idle_pct = 35;
        recv_idle_pct = 81;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_ROWS; i++)
        begin
            row = directed_rows[i];
            if (row.fill)
            begin
                for (j = 0; j < TABLE_DEPTH; j++)
                    send_beat(row.cmd, row.key + j, 1'b0, '0);
            end
            else
            begin
                send_beat(row.cmd, row.key, row.typed, '{row.code, row.status, row.is_new});
            end
        end

        run_random(RAND_PER_PHASE, 1'b0);
        wait_all_results();

        send_idle_pct = 81;
        recv_idle_pct = 35;
        run_random(RAND_PER_PHASE, 1'b0);
        wait_all_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RAND_PER_PHASE, 1'b1);
        wait_all_results();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_codes.size() != 0)
            errors += pending_codes.size();

        $display("%0d commands sent, %0d results checked, %0d keys appended", beats_in,
                 beats_out, new_keys_seen);
        $display("status counts: ok %0d, not found %0d, duplicate %0d, full %0d, errors %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3], errors);
        if (errors == 0)
            $display("[dictionary_code_assigner_core] OK");
        else
            $display("[dictionary_code_assigner_core] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/dca_pkg.sv
src/dca_ctrl.sv
src/dca_datapath.sv
src/dictionary_code_assigner_core.sv
bench/tb_dictionary_code_assigner_core.sv
